[rtl/core/xor_checked_frame_receiver_core_assert.svh]
`ifndef XOR_CHECKED_FRAME_RECEIVER_CORE_ASSERT_SVH
`define XOR_CHECKED_FRAME_RECEIVER_CORE_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define XCFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the following cycle.
`define XCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/xcfr_pkg.sv]
package xcfr_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'h53;
    localparam logic [7:0] HDR_SECOND = 8'h43;

    localparam logic [2:0] LEADER_END   = 3'(3 + 3);
    localparam logic [2:0] FOLLOWER_END = 3'(3 + 4);

    localparam logic [1:0] REG_ROLE        = 2'd0;
    localparam logic [1:0] REG_FINISH_MASK = 2'd1;
    localparam logic [1:0] REG_LOST_MASK   = 2'd2;
    localparam logic [1:0] REG_READY_MASK  = 2'd3;

    localparam logic       ROLE_RESET        = 1'b0;
    localparam logic [7:0] FINISH_MASK_RESET = 8'd1;
    localparam logic [7:0] LOST_MASK_RESET   = 8'd2;
    localparam logic [7:0] READY_MASK_RESET  = 8'd4;

    typedef struct packed {
        logic       role;
        logic [7:0] finish_mask;
        logic [7:0] lost_mask;
        logic [7:0] ready_mask;
    } cfg_t;

    // Sets every mask bit when the source hits the mask, else clears them.
    function automatic logic [7:0] apply_mask(input logic [7:0] flags,
                                              input logic [7:0] src,
                                              input logic [7:0] mask);
        logic [7:0] result;
        if ((src & mask) != 8'd0)
        begin
            result = flags | mask;
        end
        else
        begin
            result = flags & ~mask;
        end
        return result;
    endfunction

endpackage

[rtl/core/xcfr_if.sv]
interface xcfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface xcfr_res_if;
    logic        valid;
    logic        ready;
    logic        frame_ok;
    logic [15:0] distance;
    logic [7:0]  flag_bits;
    logic [7:0]  track_type;

    modport source (output valid, output frame_ok, output distance, output flag_bits,
                    output track_type, input ready);
    modport sink (input valid, input frame_ok, input distance, input flag_bits,
                  input track_type, output ready);
endinterface

[rtl/core/xor_checked_frame_receiver_core.sv]
// Frame receiver for 'S','C' framed packets with an XOR checksum.
// The rx channel carries one received byte per beat; the res channel carries
// one beat per completed frame with the pass flag and the held distance, flag
// byte and track type as they stand after that frame. Bytes that do not end a
// frame produce no result beat.
// An APB port holds the role and the three flag masks at word addresses 0 to 3.
// Each rx beat is processed in the cycle it is accepted, and the result beat
// is presented from an output register in the next cycle. A new byte can be
// accepted in every cycle unless a full result register stalls rx, as below.
// If the result register is full and res.ready is low, rx.ready drops until
// the pending beat is taken; no beat is lost or repeated.
// Reset returns the parser to the header hunt, clears the checksum and held
// values, empties the result register and loads the register defaults.
module xor_checked_frame_receiver_core (
    input  logic          clk,
    input  logic          rst_n,
    xcfr_rx_if.sink       rx,
    xcfr_res_if.source    res,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import xcfr_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_write;
    logic [1:0] reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.role        <= ROLE_RESET;
            cfg_reg.finish_mask <= FINISH_MASK_RESET;
            cfg_reg.lost_mask   <= LOST_MASK_RESET;
            cfg_reg.ready_mask  <= READY_MASK_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_ROLE:        cfg_reg.role        <= pwdata[0];
                REG_FINISH_MASK: cfg_reg.finish_mask <= pwdata[7:0];
                REG_LOST_MASK:   cfg_reg.lost_mask   <= pwdata[7:0];
                REG_READY_MASK:  cfg_reg.ready_mask  <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_ROLE:        prdata = {31'd0, cfg_reg.role};
            REG_FINISH_MASK: prdata = {24'd0, cfg_reg.finish_mask};
            REG_LOST_MASK:   prdata = {24'd0, cfg_reg.lost_mask};
            REG_READY_MASK:  prdata = {24'd0, cfg_reg.ready_mask};
            default:         prdata = 32'd0;
        endcase
    end

    xcfr_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (rx.valid),
        .in_ready       (rx.ready),
        .in_byte        (rx.rx_byte),
        .out_valid      (res.valid),
        .out_ready      (res.ready),
        .out_frame_ok   (res.frame_ok),
        .out_distance   (res.distance),
        .out_flag_bits  (res.flag_bits),
        .out_track_type (res.track_type)
    );

endmodule

[rtl/core/xcfr_parser.sv]
`include "xor_checked_frame_receiver_core_assert.svh"

module xcfr_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  xcfr_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          out_frame_ok,
    output logic [15:0]   out_distance,
    output logic [7:0]    out_flag_bits,
    output logic [7:0]    out_track_type
);
    import xcfr_pkg::*;

    localparam logic [2:0] POS_HUNT_S   = 3'd0;
    localparam logic [2:0] POS_HUNT_C   = 3'd1;
    localparam logic [2:0] POS_DIST_HI  = 3'd2;
    localparam logic [2:0] POS_DIST_LO  = 3'd3;
    localparam logic [2:0] POS_FLAG_SRC = 3'd4;
    localparam logic [2:0] POS_TRACK    = 3'd5;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  dist_hi_reg, dist_hi_next;
    logic [7:0]  dist_lo_reg, dist_lo_next;
    logic [7:0]  flag_src_reg, flag_src_next;
    logic [7:0]  track_src_reg, track_src_next;
    logic [15:0] held_dist_reg, held_dist_next;
    logic [7:0]  held_flags_reg, held_flags_next;
    logic [7:0]  held_track_reg, held_track_next;
    logic        out_valid_reg;
    logic        ok_reg;
    logic [15:0] dist_out_reg;
    logic [7:0]  flags_out_reg;
    logic [7:0]  track_out_reg;

    logic        accept;
    logic        emit;
    logic        ok;
    logic [7:0]  xor_cur;
    logic [2:0]  pos_inc;
    logic [2:0]  end_pos;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        pos_next        = pos_reg;
        xor_next        = xor_reg;
        dist_hi_next    = dist_hi_reg;
        dist_lo_next    = dist_lo_reg;
        flag_src_next   = flag_src_reg;
        track_src_next  = track_src_reg;
        held_dist_next  = held_dist_reg;
        held_flags_next = held_flags_reg;
        held_track_next = held_track_reg;
        emit            = 1'b0;
        ok              = 1'b0;
        xor_cur         = (pos_reg == POS_DIST_HI) ? 8'd0 : xor_reg;
        pos_inc         = pos_reg + 3'd1;
        end_pos         = cfg.role ? FOLLOWER_END : LEADER_END;
        case (pos_reg)
            POS_HUNT_S:
            begin
                if (in_byte == HDR_FIRST)
                begin
                    pos_next = POS_HUNT_C;
                end
            end
            POS_HUNT_C:
            begin
                pos_next = (in_byte == HDR_SECOND) ? POS_DIST_HI : POS_HUNT_S;
            end
            default:
            begin
                case (pos_reg)
                    POS_DIST_HI:  dist_hi_next   = in_byte;
                    POS_DIST_LO:  dist_lo_next   = in_byte;
                    POS_FLAG_SRC: flag_src_next  = in_byte;
                    POS_TRACK:    track_src_next = in_byte;
                    default:      ;
                endcase
                if (pos_inc < end_pos)
                begin
                    xor_next = xor_cur ^ in_byte;
                    pos_next = pos_inc;
                end
                else
                begin
                    emit     = 1'b1;
                    ok       = (in_byte == xor_cur);
                    xor_next = xor_cur;
                    pos_next = POS_HUNT_S;
                    if (ok)
                    begin
                        held_dist_next = {dist_hi_reg, dist_lo_reg};
                        if (!cfg.role)
                        begin
                            held_flags_next = apply_mask(held_flags_reg, flag_src_reg,
                                                         cfg.finish_mask);
                        end
                        else
                        begin
                            held_flags_next = apply_mask(
                                apply_mask(held_flags_reg, flag_src_reg, cfg.lost_mask),
                                flag_src_reg, cfg.ready_mask);
                            held_track_next = track_src_reg;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= POS_HUNT_S;
            xor_reg        <= 8'd0;
            held_dist_reg  <= 16'd0;
            held_flags_reg <= 8'd0;
            held_track_reg <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg        <= pos_next;
                xor_reg        <= xor_next;
                held_dist_reg  <= held_dist_next;
                held_flags_reg <= held_flags_next;
                held_track_reg <= held_track_next;
            end
            if (accept && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dist_hi_reg   <= dist_hi_next;
            dist_lo_reg   <= dist_lo_next;
            flag_src_reg  <= flag_src_next;
            track_src_reg <= track_src_next;
        end
        if (accept && emit)
        begin
            ok_reg        <= ok;
            dist_out_reg  <= held_dist_next;
            flags_out_reg <= held_flags_next;
            track_out_reg <= held_track_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_frame_ok   = ok_reg;
    assign out_distance   = dist_out_reg;
    assign out_flag_bits  = flags_out_reg;
    assign out_track_type = track_out_reg;

    `XCFR_ASSERT_NOW(a_pos_in_range, clk, rst_n, 1'b1, pos_reg != 3'd7,
        "Frame position reached an unused value.")
    `XCFR_ASSERT_NOW(a_out_matches_held, clk, rst_n, out_valid_reg,
        dist_out_reg == held_dist_reg && flags_out_reg == held_flags_reg
        && track_out_reg == held_track_reg,
        "Pending result differs from the held values.")
    `XCFR_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !in_ready, out_valid_reg,
        "Input stalled with an empty result register.")
    `XCFR_ASSERT_NEXT(a_bad_second_byte, clk, rst_n,
        accept && pos_reg == POS_HUNT_C && in_byte != HDR_SECOND,
        pos_reg == POS_HUNT_S,
        "A wrong second header byte did not restart the hunt.")

endmodule
